// ===== rtl/grl_pkg.sv =====
// Shared constants, codes and types of the gradient line rasterizer.
package grl_pkg;

  // Coordinate width used when the top level is not told otherwise
  localparam int COORD_BITS_DEFAULT = 12;

  // Configuration register widths
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 11;
  localparam int BPP_W    = 6;
  localparam int STRIDE_W = 14;

  // Configuration reset values
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [BPP_W-1:0]    BPP_RST    = 6'd32;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 14'd2560;

  // Configuration write channel
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Pixel payload
  localparam int COLOUR_W = 8;
  localparam int NUM_CHAN = 3;
  localparam int ADDR_W   = 25;
  // The address uses the low bits of an in-image coordinate
  localparam int PIX_IDX_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 4'd0,
    REG_IMAGE_HEIGHT   = 4'd1,
    REG_BITS_PER_PIXEL = 4'd2,
    REG_ROW_STRIDE     = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

endpackage

// ===== rtl/grl_if.sv =====
// Channel interfaces of the gradient line rasterizer: line items, pixels, configuration.
interface grl_item_if #(
  parameter int CW = grl_pkg::COORD_BITS_DEFAULT
);
  import grl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [CW-1:0]       start_x;
  logic signed [CW-1:0]       start_y;
  logic signed [CW-1:0]       end_x;
  logic signed [CW-1:0]       end_y;
  logic        [COLOUR_W-1:0] start_red;
  logic        [COLOUR_W-1:0] start_green;
  logic        [COLOUR_W-1:0] start_blue;
  logic        [COLOUR_W-1:0] end_red;
  logic        [COLOUR_W-1:0] end_green;
  logic        [COLOUR_W-1:0] end_blue;

  modport source (
    output valid, operation, start_x, start_y, end_x, end_y,
           start_red, start_green, start_blue, end_red, end_green, end_blue,
    input  ready
  );
  modport sink (
    input  valid, operation, start_x, start_y, end_x, end_y,
           start_red, start_green, start_blue, end_red, end_green, end_blue,
    output ready
  );
endinterface

interface grl_pixel_if #(
  parameter int CW = grl_pkg::COORD_BITS_DEFAULT
);
  import grl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [CW-1:0]       pixel_x;
  logic signed [CW-1:0]       pixel_y;
  logic        [COLOUR_W-1:0] pixel_red;
  logic        [COLOUR_W-1:0] pixel_green;
  logic        [COLOUR_W-1:0] pixel_blue;
  logic                       write_enable;
  logic        [ADDR_W-1:0]   byte_address;
  logic                       last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           write_enable, byte_address, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
           write_enable, byte_address, last_pixel,
    output ready
  );
endinterface

interface grl_cfg_if;
  import grl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gradient_line_rasterizer.sv =====
// Top level of the gradient line rasterizer: Bresenham walker with colour interpolation.
//
// Channels: item_i takes line items (operation 0 loads end points and end colours,
// operation 1 is one step tick), pixel_o gives at most one pixel per tick, and
// cfg_i writes the image width, height, bits per pixel and row stride.
// A beat moves on any channel when valid and ready are both high.
// A load is taken in the idle state. A tick on an idle walker is dropped.
// A tick on an active line passes through the stop test and the address state to the
// emit state, which stores its pixel; the final pixel of a line is presented and the
// block is ready again in the same cycle. After any other pixel the colour update
// runs through one shared restoring divider, one channel after another for three
// channels, each set up and then divided, followed by one Bresenham step.
// item_i.ready is high only between ticks. The pixel output register holds one
// beat; while the receiver stalls, the next tick works up to the point where its
// pixel has to be stored and waits there.
// Reset returns the configuration to 640 x 480, 32 bits per pixel, 2560-byte
// stride, leaves no line active and empties the output register.
// cfg_i is always ready; write it only while the block is idle.
module gradient_line_rasterizer #(
  parameter int COORD_BITS = grl_pkg::COORD_BITS_DEFAULT
) (
  input logic       clk_i,
  input logic       rst_ni,
  grl_item_if.sink  item_i,
  grl_pixel_if.source pixel_o,
  grl_cfg_if.sink   cfg_i
);
  import grl_pkg::*;

  // Position, deltas, error term, distance, bound-test, address-product, bit-counter and channel widths
  localparam int CW = COORD_BITS;
  localparam int PW = CW + 1;
  localparam int EW = PW + 2;
  localparam int DW = PW + 2;
  localparam int XW = (PW > PIX_IDX_W + 1) ? PW : PIX_IDX_W + 1;
  localparam int PXW = PIX_IDX_W + BPP_W;
  localparam int CNT_W = $clog2(COLOUR_W);
  localparam int CH_W = $clog2(NUM_CHAN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_ADDR,
    S_EMIT,
    S_DLOAD,
    S_DIV,
    S_STEP
  } state_e;

  // Control registers
  state_e                state_q, state_d;
  logic                  active_q, active_d;
  logic                  out_valid_q, out_valid_d;
  logic [WIDTH_W-1:0]    width_q, width_d;
  logic [HEIGHT_W-1:0]   height_q, height_d;
  logic [BPP_W-1:0]      bpp_q, bpp_d;
  logic [STRIDE_W-1:0]   stride_q, stride_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Datapath registers
  logic signed [PW-1:0]  cx_q, cx_d, cy_q, cy_d, tx_q, tx_d, ty_q, ty_d;
  logic [COLOUR_W-1:0]   cur_col_q [NUM_CHAN];
  logic [COLOUR_W-1:0]   cur_col_d [NUM_CHAN];
  logic [COLOUR_W-1:0]   tgt_col_q [NUM_CHAN];
  logic [COLOUR_W-1:0]   tgt_col_d [NUM_CHAN];
  logic [PW-1:0]         adx_q, adx_d, ady_q, ady_d;
  logic                  sx_q, sx_d, sy_q, sy_d;
  logic signed [EW-1:0]  err_q, err_d;
  logic [DW-1:0]         dist_q, dist_d;
  logic                  last_q, last_d, inside_q, inside_d;
  logic [PXW-1:0]        prodx_q, prodx_d;
  logic [ADDR_W-1:0]     prody_q, prody_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [COLOUR_W-1:0]   num_q, num_d, quo_q, quo_d;
  logic [DW-1:0]         rem_q, rem_d;
  logic                  neg_q, neg_d;

  // Output payload registers
  logic signed [CW-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [COLOUR_W-1:0]   ored_q, ored_d, ogreen_q, ogreen_d, oblue_q, oblue_d;
  logic                  owe_q, owe_d, olast_q, olast_d;
  logic [ADDR_W-1:0]     oaddr_q, oaddr_d;

  // Handshakes
  logic in_acc, out_acc, out_free;

  assign item_i.ready = (state_q == S_IDLE);
  assign in_acc       = item_i.valid & item_i.ready;
  assign out_acc      = pixel_o.valid & pixel_o.ready;
  assign out_free     = ~out_valid_q | pixel_o.ready;
  assign cfg_i.ready  = 1'b1;

  assign pixel_o.valid        = out_valid_q;
  assign pixel_o.pixel_x      = ox_q;
  assign pixel_o.pixel_y      = oy_q;
  assign pixel_o.pixel_red    = ored_q;
  assign pixel_o.pixel_green  = ogreen_q;
  assign pixel_o.pixel_blue   = oblue_q;
  assign pixel_o.write_enable = owe_q;
  assign pixel_o.byte_address = oaddr_q;
  assign pixel_o.last_pixel   = olast_q;

  // Load-time deltas and step directions
  logic signed [PW:0] ld_dx, ld_dy;
  logic [PW-1:0]      ld_adx, ld_ady;

  assign ld_dx  = (PW+1)'(item_i.end_x) - (PW+1)'(item_i.start_x);
  assign ld_dy  = (PW+1)'(item_i.end_y) - (PW+1)'(item_i.start_y);
  assign ld_adx = (ld_dx < 0) ? PW'(-ld_dx) : PW'(ld_dx);
  assign ld_ady = (ld_dy < 0) ? PW'(-ld_dy) : PW'(ld_dy);

  // Stop and bound tests on the current point
  logic signed [XW-1:0] xe, ye, txe, tye, wse, hse;
  logic                 beyond, at_end, in_img;

  assign xe  = XW'(cx_q);
  assign ye  = XW'(cy_q);
  assign txe = XW'(tx_q);
  assign tye = XW'(ty_q);
  assign wse = XW'($signed({1'b0, width_q}));
  assign hse = XW'($signed({1'b0, height_q}));

  assign beyond = (xe < 0 && txe < 0) || (ye < 0 && tye < 0) ||
                  (xe > wse && txe > wse) || (ye > hse && tye > hse);
  assign at_end = (cx_q == tx_q) && (cy_q == ty_q);
  assign in_img = (xe > 0) && (xe < wse) && (ye > 0) && (ye < hse);

  // Remaining Manhattan distance
  logic signed [PW:0] rem_dx, rem_dy;
  logic [PW:0]        rem_adx, rem_ady;

  assign rem_dx  = (PW+1)'(tx_q) - (PW+1)'(cx_q);
  assign rem_dy  = (PW+1)'(ty_q) - (PW+1)'(cy_q);
  assign rem_adx = (rem_dx < 0) ? (PW+1)'(-rem_dx) : (PW+1)'(rem_dx);
  assign rem_ady = (rem_dy < 0) ? (PW+1)'(-rem_dy) : (PW+1)'(rem_dy);

  // Shared divider step: one quotient bit a cycle
  logic [DW:0]         div_shift;
  logic                div_ge;
  logic [COLOUR_W-1:0] div_quo;
  logic [COLOUR_W-1:0] ch_cur, ch_tgt;

  assign div_shift = {rem_q, num_q[COLOUR_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dist_q});
  assign div_quo   = {quo_q[COLOUR_W-2:0], div_ge};
  assign ch_cur    = cur_col_q[ch_q];
  assign ch_tgt    = tgt_col_q[ch_q];

  // Bresenham step decisions
  logic signed [EW-1:0] adx_s, ady_s;
  logic                 step_x, step_y;

  assign adx_s  = $signed(EW'(adx_q));
  assign ady_s  = $signed(EW'(ady_q));
  assign step_x = (err_q > -adx_s);
  assign step_y = (err_q < ady_s);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    width_d     = width_q;
    height_d    = height_q;
    bpp_d       = bpp_q;
    stride_d    = stride_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    cur_col_d   = cur_col_q;
    tgt_col_d   = tgt_col_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    err_d       = err_q;
    dist_d      = dist_q;
    last_d      = last_q;
    inside_d    = inside_q;
    prodx_d     = prodx_q;
    prody_d     = prody_q;
    addr_d      = addr_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    ored_d      = ored_q;
    ogreen_d    = ogreen_q;
    oblue_d     = oblue_q;
    owe_d       = owe_q;
    olast_d     = olast_q;
    oaddr_d     = oaddr_q;

    // Configuration writes
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_IMAGE_WIDTH:    width_d  = cfg_i.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   height_d = cfg_i.data[HEIGHT_W-1:0];
        REG_BITS_PER_PIXEL: bpp_d    = cfg_i.data[BPP_W-1:0];
        REG_ROW_STRIDE:     stride_d = cfg_i.data[STRIDE_W-1:0];
        default: ;
      endcase
    end

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (item_i.operation == OP_LOAD) begin
            cx_d         = PW'(item_i.start_x);
            cy_d         = PW'(item_i.start_y);
            tx_d         = PW'(item_i.end_x);
            ty_d         = PW'(item_i.end_y);
            cur_col_d[0] = item_i.start_red;
            cur_col_d[1] = item_i.start_green;
            cur_col_d[2] = item_i.start_blue;
            tgt_col_d[0] = item_i.end_red;
            tgt_col_d[1] = item_i.end_green;
            tgt_col_d[2] = item_i.end_blue;
            adx_d        = ld_adx;
            ady_d        = ld_ady;
            sx_d         = (item_i.start_x < item_i.end_x);
            sy_d         = (item_i.start_y < item_i.end_y);
            err_d        = (ld_adx > ld_ady) ? $signed(EW'(ld_adx >> 1))
                                             : -$signed(EW'(ld_ady >> 1));
            active_d     = 1'b1;
          end else if (active_q) begin
            state_d = S_TEST;
          end
        end
      end

      // Stop test, bounds, distance and address products
      S_TEST: begin
        last_d   = beyond | at_end;
        inside_d = in_img;
        dist_d   = DW'(rem_adx) + DW'(rem_ady);
        prodx_d  = PXW'(xe[PIX_IDX_W-1:0]) * PXW'(bpp_q);
        prody_d  = ADDR_W'(ye[PIX_IDX_W-1:0]) * ADDR_W'(stride_q);
        state_d  = S_ADDR;
      end

      S_ADDR: begin
        addr_d  = inside_q ? ADDR_W'(prodx_q[PXW-1:3]) + prody_q : '0;
        state_d = S_EMIT;
      end

      // Store the pixel once the output register is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ox_d        = cx_q[CW-1:0];
          oy_d        = cy_q[CW-1:0];
          ored_d      = cur_col_q[0];
          ogreen_d    = cur_col_q[1];
          oblue_d     = cur_col_q[2];
          owe_d       = inside_q;
          olast_d     = last_q;
          oaddr_d     = addr_q;
          if (last_q) begin
            active_d = 1'b0;
            state_d  = S_IDLE;
          end else begin
            ch_d    = '0;
            state_d = S_DLOAD;
          end
        end
      end

      // Set up the divider for one channel
      S_DLOAD: begin
        neg_d   = (ch_tgt < ch_cur);
        num_d   = (ch_tgt < ch_cur) ? ch_cur - ch_tgt : ch_tgt - ch_cur;
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = CNT_W'(COLOUR_W - 1);
        state_d = S_DIV;
      end

      S_DIV: begin
        rem_d = div_ge ? DW'(div_shift - {1'b0, dist_q}) : div_shift[DW-1:0];
        num_d = num_q << 1;
        quo_d = div_quo;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cur_col_d[ch_q] = neg_q ? ch_cur - div_quo : ch_cur + div_quo;
          if (ch_q == CH_W'(NUM_CHAN - 1)) begin
            state_d = S_STEP;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_DLOAD;
          end
        end
      end

      // Bresenham step
      S_STEP: begin
        err_d = err_q - (step_x ? ady_s : EW'(0)) + (step_y ? adx_s : EW'(0));
        if (step_x) begin
          cx_d = cx_q + (sx_q ? PW'(1) : {PW{1'b1}});
        end
        if (step_y) begin
          cy_d = cy_q + (sy_q ? PW'(1) : {PW{1'b1}});
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, datapath and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      bpp_q       <= BPP_RST;
      stride_q    <= STRIDE_RST;
      ch_q        <= '0;
      cnt_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      cur_col_q   <= '{default: '0};
      tgt_col_q   <= '{default: '0};
      adx_q       <= '0;
      ady_q       <= '0;
      sx_q        <= 1'b0;
      sy_q        <= 1'b0;
      err_q       <= '0;
      dist_q      <= '0;
      last_q      <= 1'b0;
      inside_q    <= 1'b0;
      prodx_q     <= '0;
      prody_q     <= '0;
      addr_q      <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      ored_q      <= '0;
      ogreen_q    <= '0;
      oblue_q     <= '0;
      owe_q       <= 1'b0;
      olast_q     <= 1'b0;
      oaddr_q     <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      width_q     <= width_d;
      height_q    <= height_d;
      bpp_q       <= bpp_d;
      stride_q    <= stride_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      tx_q        <= tx_d;
      ty_q        <= ty_d;
      cur_col_q   <= cur_col_d;
      tgt_col_q   <= tgt_col_d;
      adx_q       <= adx_d;
      ady_q       <= ady_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      err_q       <= err_d;
      dist_q      <= dist_d;
      last_q      <= last_d;
      inside_q    <= inside_d;
      prodx_q     <= prodx_d;
      prody_q     <= prody_d;
      addr_q      <= addr_d;
      num_q       <= num_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      neg_q       <= neg_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      ored_q      <= ored_d;
      ogreen_q    <= ogreen_d;
      oblue_q     <= oblue_d;
      owe_q       <= owe_d;
      olast_q     <= olast_d;
      oaddr_q     <= oaddr_d;
    end
  end

  // A line goes idle only with its final pixel stored in the output register
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> out_valid_q && olast_q)
    else $error("line went idle without a final pixel");

  // The divider never runs on a zero distance
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dist_q != '0))
    else $error("colour division by zero distance");

  // Restoring divider keeps its remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dist_q))
    else $error("divider remainder out of range");

  // Pixels outside the image carry a zero address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !owe_q) |-> (oaddr_q == '0))
    else $error("address set on a pixel outside the image");

  // Only a tick on an active line leaves the idle state
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> $past(in_acc) && $past(active_q))
    else $error("stepping started without an active line");

endmodule

// ===== dv/tb_gradient_line_rasterizer.sv =====
// Self-checking testbench for the gradient line rasterizer: line walks, colour steps, addresses.
`timescale 1ns / 1ps

module tb_gradient_line_rasterizer;
  import grl_pkg::*;

  localparam int CW        = COORD_BITS_DEFAULT;
  localparam int COORD_MIN = -(1 << (CW - 1));
  localparam int COORD_MAX = (1 << (CW - 1)) - 1;

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYC  = 40;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    op_e                 op;
    logic [CW-1:0]       start_x;
    logic [CW-1:0]       start_y;
    logic [CW-1:0]       end_x;
    logic [CW-1:0]       end_y;
    logic [COLOUR_W-1:0] start_red;
    logic [COLOUR_W-1:0] start_green;
    logic [COLOUR_W-1:0] start_blue;
    logic [COLOUR_W-1:0] end_red;
    logic [COLOUR_W-1:0] end_green;
    logic [COLOUR_W-1:0] end_blue;
  } line_item_t;

  typedef struct packed {
    logic [CW-1:0]       x;
    logic [CW-1:0]       y;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic                last;
  } pixel_t;

  // Walks the line alongside the block and keeps the pixels still owed by it
  class pixel_scoreboard;
    logic [WIDTH_W-1:0]  img_w;
    logic [HEIGHT_W-1:0] img_h;
    logic [BPP_W-1:0]    img_bpp;
    logic [STRIDE_W-1:0] img_stride;

    int cur_x, cur_y, dst_x, dst_y;
    int cur_c[NUM_CHAN];
    int dst_c[NUM_CHAN];
    int adx, ady, err;
    bit x_up, y_up, active;

    pixel_t pixel_q[$];
    int     faults;

    function new();
      img_w      = WIDTH_RST;
      img_h      = HEIGHT_RST;
      img_bpp    = BPP_RST;
      img_stride = STRIDE_RST;
      cur_x = 0; cur_y = 0; dst_x = 0; dst_y = 0;
      foreach (cur_c[i]) begin
        cur_c[i] = 0;
        dst_c[i] = 0;
      end
      adx = 0; ady = 0; err = 0;
      x_up = 0; y_up = 0; active = 0;
      faults = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:    img_w      = data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   img_h      = data[HEIGHT_W-1:0];
        REG_BITS_PER_PIXEL: img_bpp    = data[BPP_W-1:0];
        REG_ROW_STRIDE:     img_stride = data[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function bit line_active();
      return active;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // Stop when the end is reached or both points sit beyond one image edge
    function bit walk_continues();
      int w, h;
      w = int'(img_w);
      h = int'(img_h);
      if (cur_x < 0 && dst_x < 0) return 0;
      if (cur_y < 0 && dst_y < 0) return 0;
      if (cur_x > w && dst_x > w) return 0;
      if (cur_y > h && dst_y > h) return 0;
      if (cur_x == dst_x && cur_y == dst_y) return 0;
      return 1;
    endfunction

    function pixel_t pixel_here(bit last);
      pixel_t p;
      bit     in_img;
      longint addr;
      in_img = cur_x > 0 && cur_x < int'(img_w) &&
               cur_y > 0 && cur_y < int'(img_h);
      addr = 0;
      if (in_img)
        addr = ((longint'(cur_x) * int'(img_bpp)) >> 3) +
               longint'(cur_y) * int'(img_stride);
      p.x     = cur_x[CW-1:0];
      p.y     = cur_y[CW-1:0];
      p.red   = cur_c[0][COLOUR_W-1:0];
      p.green = cur_c[1][COLOUR_W-1:0];
      p.blue  = cur_c[2][COLOUR_W-1:0];
      p.we    = in_img;
      p.addr  = addr[ADDR_W-1:0];
      p.last  = last;
      return p;
    endfunction

    // Called for every accepted item beat
    function void note_item(line_item_t it);
      int steps_left, prev;
      if (it.op == OP_LOAD) begin
        cur_x = int'($signed(it.start_x));
        cur_y = int'($signed(it.start_y));
        dst_x = int'($signed(it.end_x));
        dst_y = int'($signed(it.end_y));
        cur_c[0] = it.start_red;
        cur_c[1] = it.start_green;
        cur_c[2] = it.start_blue;
        dst_c[0] = it.end_red;
        dst_c[1] = it.end_green;
        dst_c[2] = it.end_blue;
        adx  = (dst_x > cur_x) ? dst_x - cur_x : cur_x - dst_x;
        ady  = (dst_y > cur_y) ? dst_y - cur_y : cur_y - dst_y;
        x_up = cur_x < dst_x;
        y_up = cur_y < dst_y;
        err  = (adx > ady ? adx : -ady) / 2;
        active = 1;
        return;
      end
      // tick on an idle walker is dropped
      if (!active) return;
      if (!walk_continues()) begin
        pixel_q.push_back(pixel_here(1'b1));
        active = 0;
        return;
      end
      pixel_q.push_back(pixel_here(1'b0));
      steps_left = ((dst_x > cur_x) ? dst_x - cur_x : cur_x - dst_x) +
                   ((dst_y > cur_y) ? dst_y - cur_y : cur_y - dst_y);
      prev = err;
      foreach (cur_c[i]) cur_c[i] += (dst_c[i] - cur_c[i]) / steps_left;
      if (prev > -adx) begin
        err   -= ady;
        cur_x += x_up ? 1 : -1;
      end
      if (prev < ady) begin
        err   += adx;
        cur_y += y_up ? 1 : -1;
      end
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        faults++;
      end
    endfunction

    // Called for every accepted pixel beat
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        $error("pixel beat with nothing expected: x %0d y %0d",
               $signed(got.x), $signed(got.y));
        faults++;
        return;
      end
      want = pixel_q.pop_front();
      field_check("pixel_x", longint'($signed(want.x)), longint'($signed(got.x)));
      field_check("pixel_y", longint'($signed(want.y)), longint'($signed(got.y)));
      field_check("pixel_red", want.red, got.red);
      field_check("pixel_green", want.green, got.green);
      field_check("pixel_blue", want.blue, got.blue);
      field_check("write_enable", want.we, got.we);
      field_check("byte_address", want.addr, got.addr);
      field_check("last_pixel", want.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  grl_item_if  #(.CW(CW)) item_if ();
  grl_pixel_if #(.CW(CW)) pixel_if ();
  grl_cfg_if              cfg_if ();

  gradient_line_rasterizer #(.COORD_BITS(CW)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .pixel_o (pixel_if),
    .cfg_i   (cfg_if)
  );

  pixel_scoreboard sb;

  int items_sent;
  int lines_run;
  int src_calm;
  int snk_calm;
  int idle_cycles;
  int gen_w;
  int gen_h;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Wait draw: mostly a uniformly drawn wait, now and then a run with no gaps at all
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic line_item_t rand_fields(op_e op);
    line_item_t it;
    it.op          = op;
    it.start_x     = CW'($urandom);
    it.start_y     = CW'($urandom);
    it.end_x       = CW'($urandom);
    it.end_y       = CW'($urandom);
    it.start_red   = COLOUR_W'($urandom);
    it.start_green = COLOUR_W'($urandom);
    it.start_blue  = COLOUR_W'($urandom);
    it.end_red     = COLOUR_W'($urandom);
    it.end_green   = COLOUR_W'($urandom);
    it.end_blue    = COLOUR_W'($urandom);
    return it;
  endfunction

  function automatic line_item_t mk_line(int sx, int sy, int ex, int ey,
                                         logic [23:0] c0, logic [23:0] c1);
    line_item_t it;
    it = rand_fields(OP_LOAD);
    it.start_x     = CW'(sx);
    it.start_y     = CW'(sy);
    it.end_x       = CW'(ex);
    it.end_y       = CW'(ey);
    it.start_red   = c0[23:16];
    it.start_green = c0[15:8];
    it.start_blue  = c0[7:0];
    it.end_red     = c1[23:16];
    it.end_green   = c1[15:8];
    it.end_blue    = c1[7:0];
    return it;
  endfunction

  // One item beat; fields change at the falling edge, acceptance seen at the rising edge
  task automatic send_item(line_item_t it);
    int gap;
    gap = draw_wait(src_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.operation   = it.op;
    item_if.start_x     = it.start_x;
    item_if.start_y     = it.start_y;
    item_if.end_x       = it.end_x;
    item_if.end_y       = it.end_y;
    item_if.start_red   = it.start_red;
    item_if.start_green = it.start_green;
    item_if.start_blue  = it.start_blue;
    item_if.end_red     = it.end_red;
    item_if.end_green   = it.end_green;
    item_if.end_blue    = it.end_blue;
    item_if.valid       = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    if (it.op == OP_LOAD || sb.line_active()) items_sent++;
    sb.note_item(it);
  endtask

  // Load a line, then tick until its last pixel or until the cap cuts it short
  task automatic run_line(line_item_t ld, int cap);
    int n;
    n = 0;
    send_item(ld);
    while (sb.line_active() && n < cap) begin
      send_item(rand_fields(OP_STEP));
      n++;
    end
  endtask

  // Hold the item side off until every owed pixel is out
  task automatic drain_pause();
    @(negedge clk_i);
    item_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // New image setting, written only once the walker has gone quiet
  task automatic apply_setting(int w, int h, int bpp, int stride, bit junk);
    logic [CFG_DATA_W-1:0] hi;
    drain_pause();
    repeat (SETTLE_CYC) @(negedge clk_i);
    hi = junk ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_IMAGE_WIDTH, {hi[CFG_DATA_W-1:WIDTH_W], WIDTH_W'(w)});
    write_reg(REG_IMAGE_HEIGHT, {hi[CFG_DATA_W-1:HEIGHT_W], HEIGHT_W'(h)});
    write_reg(REG_BITS_PER_PIXEL, {hi[CFG_DATA_W-1:BPP_W], BPP_W'(bpp)});
    write_reg(REG_ROW_STRIDE, {hi[CFG_DATA_W-1:STRIDE_W], STRIDE_W'(stride)});
    if (junk)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'($urandom));
    gen_w = w;
    gen_h = h;
  endtask

  // Short lines with random colours, some long or cut off, some off the image
  task automatic random_phase(int quota);
    int         base, span, cap, x0, y0, extra;
    bit         wild;
    line_item_t ld;
    base = items_sent;
    while (items_sent - base < quota) begin
      lines_run++;
      if (lines_run % 25 == 7) drain_pause();
      ld   = rand_fields(OP_LOAD);
      span = ($urandom_range(0, 19) == 0) ? 100 : 12;
      wild = $urandom_range(0, 24) == 0;
      if ($urandom_range(0, 9) < 3) begin
        x0 = int'($signed(ld.start_x));
        y0 = int'($signed(ld.start_y));
      end else begin
        x0 = $urandom_range(0, gen_w + 2) - 1;
        y0 = $urandom_range(0, gen_h + 2) - 1;
      end
      ld.start_x = CW'(x0);
      ld.start_y = CW'(y0);
      if (!wild) begin
        ld.end_x = CW'(clamp_coord(x0 + $urandom_range(0, 2 * span) - span));
        ld.end_y = CW'(clamp_coord(y0 + $urandom_range(0, 2 * span) - span));
      end
      // far-flung ends and broken sequences are cut short by a fresh load
      if (wild)
        cap = $urandom_range(1, 40);
      else if ($urandom_range(0, 7) == 0)
        cap = $urandom_range(0, 3);
      else
        cap = 1000;
      run_line(ld, cap);
      // stray ticks on an idle walker
      if (!sb.line_active() && $urandom_range(0, 9) == 0) begin
        extra = $urandom_range(1, 2);
        repeat (extra) send_item(rand_fields(OP_STEP));
      end
    end
  endtask

  // Pixel receiver with random stalls
  initial begin : pixel_sink
    int     stall;
    pixel_t got;
    pixel_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(snk_calm);
      @(negedge clk_i);
      if (stall > 0) begin
        pixel_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pixel_if.ready = 1'b1;
      do @(posedge clk_i); while (!pixel_if.valid);
      got.x     = pixel_if.pixel_x;
      got.y     = pixel_if.pixel_y;
      got.red   = pixel_if.pixel_red;
      got.green = pixel_if.pixel_green;
      got.blue  = pixel_if.pixel_blue;
      got.we    = pixel_if.write_enable;
      got.addr  = pixel_if.byte_address;
      got.last  = pixel_if.last_pixel;
      sb.check_pixel(got);
    end
  end

  // Watchdog: too long without a beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((item_if.valid && item_if.ready) || (pixel_if.valid && pixel_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("gradient_line_rasterizer: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence
  initial begin
    sb = new();
    items_sent  = 0;
    lines_run   = 0;
    src_calm    = 0;
    snk_calm    = 0;
    gen_w       = WIDTH_RST;
    gen_h       = HEIGHT_RST;

    item_if.valid       = 1'b0;
    item_if.operation   = OP_LOAD;
    item_if.start_x     = '0;
    item_if.start_y     = '0;
    item_if.end_x       = '0;
    item_if.end_y       = '0;
    item_if.start_red   = '0;
    item_if.start_green = '0;
    item_if.start_blue  = '0;
    item_if.end_red     = '0;
    item_if.end_green   = '0;
    item_if.end_blue    = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_IMAGE_WIDTH;
    cfg_if.data         = '0;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed lines on the reset image setting
    send_item(rand_fields(OP_STEP));                                     // tick while idle
    run_line(mk_line(5, 5, 5, 5, 24'h0A141E, 24'hC86400), 100);          // zero length
    run_line(mk_line(0, 0, 3, 2, 24'h000000, 24'hFFFFFF), 100);          // from the corner
    run_line(mk_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                     24'hFFFFFF, 24'h000000), 100);                      // left of the image
    run_line(mk_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                     24'hFF00FF, 24'h00FF00), 100);                      // right of the image
    run_line(mk_line(100, -5, 90, -1, 24'h808080, 24'h7F7F7F), 100);     // above the image
    run_line(mk_line(10, 700, 12, 600, 24'h123456, 24'hFEDCBA), 100);    // below the image
    run_line(mk_line(10, 10, 20, 15, 24'h00FF80, 24'hFF0080), 2);        // dropped part way
    run_line(mk_line(639, 479, 641, 481, 24'h000000, 24'hFFFFFF), 100);  // across the far corner

    // Random phases over several image settings
    random_phase(PHASE_ITEMS);
    apply_setting(2047, 2047, 32, 16383, 1'b0);
    random_phase(PHASE_ITEMS);
    apply_setting(1, 1, 8, 0, 1'b0);
    random_phase(PHASE_ITEMS);
    apply_setting(0, 0, 24, 1, 1'b1);
    random_phase(PHASE_ITEMS);
    apply_setting($urandom_range(1, 2047), $urandom_range(1, 2047),
                  $urandom_range(8, 32), $urandom_range(0, 16383), 1'b1);
    random_phase(PHASE_ITEMS);
    apply_setting($urandom_range(1, 64), $urandom_range(1, 64),
                  8 * $urandom_range(1, 4), $urandom_range(0, 16383), 1'b1);
    random_phase(PHASE_ITEMS);

    // Drain, then give the walker time to show any stray beat
    drain_pause();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("gradient_line_rasterizer: match");
    end else begin
      $display("gradient_line_rasterizer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/grl_pkg.sv
rtl/grl_if.sv
rtl/gradient_line_rasterizer.sv
dv/tb_gradient_line_rasterizer.sv
